### rtl/dnvr_pkg.sv
// shared widths, register codes, reset values and pipeline control type
// for the depth normal view reliability block; no dependencies
package dnvr_pkg;

   // field and register widths
   localparam int CENTER_W   = 16;
   localparam int INV_W      = 24;
   localparam int NORM_W     = 16;
   localparam int DEPTH_W    = 16;
   localparam int REL_W      = 16;
   localparam int PIX_FRAC   = 4;

   // ray component: unsigned magnitude in Q.16, saturated
   localparam int RAY_W      = 28;
   localparam logic [RAY_W-1:0] RAY_MAX = '1;
   localparam int RAY_SHIFT  = 12;
   localparam int SRAY_W     = RAY_W + 1;
   localparam int ONE_SHIFT  = 16;

   // dot product and squared ray length
   localparam int PROD_W     = NORM_W + SRAY_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int SQR_W      = 2 * RAY_W;
   localparam int N2_W       = 60;
   localparam logic [N2_W-1:0] N2_ONE = N2_W'(1) << (2 * ONE_SHIFT);

   // square root pipeline
   localparam int ROOT_W     = N2_W / 2;
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;

   // divider pipeline: numerator is |dot| * 4, quotient in Q0.16
   localparam int NUM_SHIFT  = 2;
   localparam int DIV_HI_SHIFT = ONE_SHIFT - NUM_SHIFT;
   localparam int DIV_STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = REL_W / DIV_STEPS_PER_STAGE;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CENTER_W-1:0] CENTER_X_RESET = 16'd5112;
   localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 16'd3832;
   localparam logic [INV_W-1:0]    INV_FOCAL_X_RESET = 24'd31957;
   localparam logic [INV_W-1:0]    INV_FOCAL_Y_RESET = 24'd31957;

   typedef enum logic [1:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_INV_FOCAL_X,
      CSR_INV_FOCAL_Y
   } csr_index_type;

   // control that travels with each pipeline stage
   typedef struct packed {
      logic valid;
      logic zero;
   } pipe_ctl_type;

endpackage

### rtl/dnvr_sqrt_pipe.sv
// pipelined digit-by-digit integer square root of the squared ray length,
// two result bits per stage; carries |dot| alongside; uses dnvr_pkg
module dnvr_sqrt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pipe_en,
   input  dnvr_pkg::pipe_ctl_type        in_ctl,
   input  logic [dnvr_pkg::DOT_W-1:0]    in_adot,
   input  logic [dnvr_pkg::N2_W-1:0]     in_rad,
   output dnvr_pkg::pipe_ctl_type        out_ctl,
   output logic [dnvr_pkg::DOT_W-1:0]    out_adot,
   output logic [dnvr_pkg::ROOT_W-1:0]   out_root
);
   import dnvr_pkg::*;

   localparam int REM_W  = ROOT_W + 2;
   localparam int WIDE_W = REM_W + 2;

   typedef struct packed {
      logic [N2_W-1:0]   rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
   } sq_state_type;

   // one root bit: bring down two radicand bits, try subtracting 4r+1
   function automatic sq_state_type sq_step(input sq_state_type cur);
      logic [WIDE_W-1:0] widened;
      logic [WIDE_W-1:0] trial;
      logic              ge;
      sq_state_type      nxt;
      widened  = {cur.rem, cur.rad[N2_W-1 -: 2]};
      trial    = WIDE_W'({cur.root, 2'b01});
      ge       = widened >= trial;
      nxt.rad  = {cur.rad[N2_W-3:0], 2'b00};
      nxt.root = {cur.root[ROOT_W-2:0], ge};
      nxt.rem  = ge ? REM_W'(widened - trial) : REM_W'(widened);
      return nxt;
   endfunction

   sq_state_type       st_ff   [SQRT_STAGES];
   pipe_ctl_type       ctl_ff  [SQRT_STAGES];
   logic [DOT_W-1:0]   adot_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      sq_state_type     src;
      sq_state_type     step_in;
      pipe_ctl_type     src_ctl;
      logic [DOT_W-1:0] src_adot;

      // stage source: pipe input or previous stage
      if (g == 0) begin : g_first
         assign src      = {in_rad, ROOT_W'(0), REM_W'(0)};
         assign src_ctl  = in_ctl;
         assign src_adot = in_adot;
      end else begin : g_next
         assign src      = st_ff[g-1];
         assign src_ctl  = ctl_ff[g-1];
         assign src_adot = adot_ff[g-1];
      end

      // root bits resolved in this stage
      always_comb begin
         sq_state_type acc;
         acc = src;
         for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
            acc = sq_step(acc);
         end
         step_in = acc;
      end

      // control register
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g] <= '0;
         end else if (pipe_en) begin
            ctl_ff[g] <= src_ctl;
         end
      end

      // data registers
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            st_ff[g]   <= step_in;
            adot_ff[g] <= src_adot;
         end
      end
   end

   assign out_ctl  = ctl_ff[SQRT_STAGES-1];
   assign out_adot = adot_ff[SQRT_STAGES-1];
   assign out_root = st_ff[SQRT_STAGES-1].root;

endmodule

### rtl/dnvr_div_pipe.sv
// pipelined restoring divider: (|dot| * 4) / root as Q0.16 with saturation
// and forced zero, two quotient bits per stage; uses dnvr_pkg
module dnvr_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pipe_en,
   input  dnvr_pkg::pipe_ctl_type        in_ctl,
   input  logic [dnvr_pkg::DOT_W-1:0]    in_adot,
   input  logic [dnvr_pkg::ROOT_W-1:0]   in_root,
   output dnvr_pkg::pipe_ctl_type        out_ctl,
   output logic [dnvr_pkg::REL_W-1:0]    out_rel
);
   import dnvr_pkg::*;

   localparam int HI_W = DOT_W - DIV_HI_SHIFT;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [REL_W-1:0]  num;
      logic [REL_W-1:0]  quo;
   } dv_state_type;

   // one quotient bit: shift in next numerator bit, subtract if it fits
   function automatic dv_state_type dv_step(input dv_state_type cur,
                                            input logic [ROOT_W-1:0] divisor);
      logic [ROOT_W:0] trial;
      logic            ge;
      dv_state_type    nxt;
      trial   = {cur.rem, cur.num[REL_W-1]};
      ge      = trial >= {1'b0, divisor};
      nxt.num = {cur.num[REL_W-2:0], 1'b0};
      nxt.quo = {cur.quo[REL_W-2:0], ge};
      nxt.rem = ge ? ROOT_W'(trial - {1'b0, divisor}) : trial[ROOT_W-1:0];
      return nxt;
   endfunction

   // setup: saturation test and first partial remainder
   logic [HI_W-1:0]   num_hi;
   logic              sat_in;
   dv_state_type      pre_in;

   assign num_hi = in_adot[DOT_W-1:DIV_HI_SHIFT];
   assign sat_in = num_hi >= HI_W'(in_root);
   assign pre_in = {num_hi[ROOT_W-1:0],
                    {in_adot[DIV_HI_SHIFT-1:0], {NUM_SHIFT{1'b0}}},
                    REL_W'(0)};

   pipe_ctl_type      pre_ctl_ff;
   logic              pre_sat_ff;
   dv_state_type      pre_st_ff;
   logic [ROOT_W-1:0] pre_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ctl_ff <= '0;
      end else if (pipe_en) begin
         pre_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pre_sat_ff <= sat_in;
         pre_st_ff  <= pre_in;
         pre_div_ff <= in_root;
      end
   end

   dv_state_type      st_ff  [DIV_STAGES];
   pipe_ctl_type      ctl_ff [DIV_STAGES];
   logic              sat_ff [DIV_STAGES];
   logic [ROOT_W-1:0] div_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      dv_state_type      src;
      dv_state_type      step_in;
      pipe_ctl_type      src_ctl;
      logic              src_sat;
      logic [ROOT_W-1:0] src_div;

      // stage source: setup register or previous stage
      if (g == 0) begin : g_first
         assign src     = pre_st_ff;
         assign src_ctl = pre_ctl_ff;
         assign src_sat = pre_sat_ff;
         assign src_div = pre_div_ff;
      end else begin : g_next
         assign src     = st_ff[g-1];
         assign src_ctl = ctl_ff[g-1];
         assign src_sat = sat_ff[g-1];
         assign src_div = div_ff[g-1];
      end

      // quotient bits resolved in this stage
      always_comb begin
         dv_state_type acc;
         acc = src;
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            acc = dv_step(acc, src_div);
         end
         step_in = acc;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g] <= '0;
         end else if (pipe_en) begin
            ctl_ff[g] <= src_ctl;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            st_ff[g]  <= step_in;
            sat_ff[g] <= src_sat;
            div_ff[g] <= src_div;
         end
      end
   end

   // final select: forced zero, saturation or quotient
   assign out_ctl = ctl_ff[DIV_STAGES-1];
   assign out_rel = ctl_ff[DIV_STAGES-1].zero ? '0 :
                    sat_ff[DIV_STAGES-1]      ? '1 :
                    st_ff[DIV_STAGES-1].quo;

endmodule

### rtl/depth_normal_view_reliability_core.sv
// Depth normal view reliability: for each depth pixel the absolute cosine between the
// surface normal and the viewing ray through that pixel, as unsigned Q0.16 saturated at
// 65535, or 0 for a masked pixel, zero depth or an invalid normal. One pixel is taken
// every clock while req_stall is low, and each result passes through six stages for the
// ray, products and sums, fifteen for the square root of the ray length (two root bits
// per stage) and nine for the divider (setup plus two quotient bits per stage), then the
// output register. A stalled output backs up into a skid register, so the input stall is
// registered and the pipeline keeps taking pixels until both output slots are full.
// Uses dnvr_pkg, dnvr_sqrt_pipe and dnvr_div_pipe.
module depth_normal_view_reliability_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [COORD_BITS-1:0]                  req_column,
   input  logic [COORD_BITS-1:0]                  req_row,
   input  logic [dnvr_pkg::DEPTH_W-1:0]           req_raw_depth,
   input  logic                                   req_masked,
   input  logic signed [dnvr_pkg::NORM_W-1:0]     req_normal_x,
   input  logic signed [dnvr_pkg::NORM_W-1:0]     req_normal_y,
   input  logic signed [dnvr_pkg::NORM_W-1:0]     req_normal_z,
   input  logic                                   req_normal_invalid,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [dnvr_pkg::REL_W-1:0]             rsp_reliability,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [dnvr_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [dnvr_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [dnvr_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import dnvr_pkg::*;

   localparam int POS_W  = COORD_BITS + PIX_FRAC;
   localparam int DIFF_W = ((POS_W > CENTER_W) ? POS_W : CENTER_W) + 1;
   localparam int DMAG_W = DIFF_W - 1;
   localparam int XPRD_W = DMAG_W + INV_W;
   localparam int SH_W   = XPRD_W - RAY_SHIFT;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [CENTER_W-1:0] center_x_ff;
   logic [CENTER_W-1:0] center_y_ff;
   logic [INV_W-1:0]    inv_focal_x_ff;
   logic [INV_W-1:0]    inv_focal_y_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= CENTER_X_RESET;
         center_y_ff    <= CENTER_Y_RESET;
         inv_focal_x_ff <= INV_FOCAL_X_RESET;
         inv_focal_y_ff <= INV_FOCAL_Y_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_ff    <= pwdata[CENTER_W-1:0];
            CSR_CENTER_Y:    center_y_ff    <= pwdata[CENTER_W-1:0];
            CSR_INV_FOCAL_X: inv_focal_x_ff <= pwdata[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_focal_y_ff <= pwdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // register read
   always_comb begin
      case (csr_index)
         CSR_CENTER_X:    prdata = CSR_DATA_W'(center_x_ff);
         CSR_CENTER_Y:    prdata = CSR_DATA_W'(center_y_ff);
         CSR_INV_FOCAL_X: prdata = CSR_DATA_W'(inv_focal_x_ff);
         CSR_INV_FOCAL_Y: prdata = CSR_DATA_W'(inv_focal_y_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // pipeline enable: hold the pipeline while the skid register is full
   // ---------------------------------------------------------------
   logic pipe_en;
   logic skid_valid_ff;

   assign pipe_en   = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------------------------------------------------------
   // stage 1: offset from principal point, magnitude and sign
   // ---------------------------------------------------------------
   logic [DIFF_W-1:0]  diff_x, diff_y, ndiff_x, ndiff_y;
   logic [DMAG_W-1:0]  dmag_x_in, dmag_y_in;
   pipe_ctl_type       ctl_s1_in;

   assign diff_x  = DIFF_W'({req_column, {PIX_FRAC{1'b0}}}) - DIFF_W'(center_x_ff);
   assign diff_y  = DIFF_W'({req_row, {PIX_FRAC{1'b0}}}) - DIFF_W'(center_y_ff);
   assign ndiff_x = -diff_x;
   assign ndiff_y = -diff_y;
   assign dmag_x_in = diff_x[DIFF_W-1] ? ndiff_x[DMAG_W-1:0] : diff_x[DMAG_W-1:0];
   assign dmag_y_in = diff_y[DIFF_W-1] ? ndiff_y[DMAG_W-1:0] : diff_y[DMAG_W-1:0];
   assign ctl_s1_in.valid = req_valid;
   assign ctl_s1_in.zero  = req_masked | (req_raw_depth == '0) | req_normal_invalid;

   pipe_ctl_type              ctl_s1_ff;
   logic [DMAG_W-1:0]         dmag_x_s1_ff, dmag_y_s1_ff;
   logic                      neg_x_s1_ff, neg_y_s1_ff;
   logic signed [NORM_W-1:0]  nx_s1_ff, ny_s1_ff, nz_s1_ff;

   // ---------------------------------------------------------------
   // stage 2: offset times reciprocal focal length
   // ---------------------------------------------------------------
   logic [XPRD_W-1:0] prod_x_in, prod_y_in;

   assign prod_x_in = dmag_x_s1_ff * inv_focal_x_ff;
   assign prod_y_in = dmag_y_s1_ff * inv_focal_y_ff;

   pipe_ctl_type              ctl_s2_ff;
   logic [XPRD_W-1:0]         prod_x_s2_ff, prod_y_s2_ff;
   logic                      neg_x_s2_ff, neg_y_s2_ff;
   logic signed [NORM_W-1:0]  nx_s2_ff, ny_s2_ff, nz_s2_ff;

   // ---------------------------------------------------------------
   // stage 3: scale to Q.16, saturate, restore sign
   // ---------------------------------------------------------------
   logic [SH_W-1:0]           sh_x, sh_y;
   logic [RAY_W-1:0]          mag_x_in, mag_y_in;
   logic signed [SRAY_W-1:0]  ray_x_in, ray_y_in;

   assign sh_x     = prod_x_s2_ff[XPRD_W-1:RAY_SHIFT];
   assign sh_y     = prod_y_s2_ff[XPRD_W-1:RAY_SHIFT];
   assign mag_x_in = (sh_x > SH_W'(RAY_MAX)) ? RAY_MAX : sh_x[RAY_W-1:0];
   assign mag_y_in = (sh_y > SH_W'(RAY_MAX)) ? RAY_MAX : sh_y[RAY_W-1:0];
   assign ray_x_in = neg_x_s2_ff ? -{1'b0, mag_x_in} : {1'b0, mag_x_in};
   assign ray_y_in = neg_y_s2_ff ? -{1'b0, mag_y_in} : {1'b0, mag_y_in};

   pipe_ctl_type              ctl_s3_ff;
   logic [RAY_W-1:0]          mag_x_s3_ff, mag_y_s3_ff;
   logic signed [SRAY_W-1:0]  ray_x_s3_ff, ray_y_s3_ff;
   logic signed [NORM_W-1:0]  nx_s3_ff, ny_s3_ff, nz_s3_ff;

   // ---------------------------------------------------------------
   // stage 4: normal times ray, squared ray components
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0]  px_in, py_in;
   logic [SQR_W-1:0]          sqx_in, sqy_in;

   assign px_in  = nx_s3_ff * ray_x_s3_ff;
   assign py_in  = ny_s3_ff * ray_y_s3_ff;
   assign sqx_in = mag_x_s3_ff * mag_x_s3_ff;
   assign sqy_in = mag_y_s3_ff * mag_y_s3_ff;

   pipe_ctl_type              ctl_s4_ff;
   logic signed [PROD_W-1:0]  px_s4_ff, py_s4_ff;
   logic [SQR_W-1:0]          sqx_s4_ff, sqy_s4_ff;
   logic signed [NORM_W-1:0]  nz_s4_ff;

   // ---------------------------------------------------------------
   // stage 5: dot product and squared ray length (ray z is 1.0)
   // ---------------------------------------------------------------
   logic [DOT_W-1:0] dot_in;
   logic [N2_W-1:0]  rad_in;

   assign dot_in = {{(DOT_W-PROD_W){px_s4_ff[PROD_W-1]}}, px_s4_ff}
                 + {{(DOT_W-PROD_W){py_s4_ff[PROD_W-1]}}, py_s4_ff}
                 + {{(DOT_W-NORM_W-ONE_SHIFT){nz_s4_ff[NORM_W-1]}}, nz_s4_ff,
                    {ONE_SHIFT{1'b0}}};
   assign rad_in = N2_W'(sqx_s4_ff) + N2_W'(sqy_s4_ff) + N2_ONE;

   pipe_ctl_type     ctl_s5_ff;
   logic [DOT_W-1:0] dot_s5_ff;
   logic [N2_W-1:0]  rad_s5_ff;

   // ---------------------------------------------------------------
   // stage 6: absolute dot product
   // ---------------------------------------------------------------
   logic [DOT_W-1:0] adot_in;

   assign adot_in = dot_s5_ff[DOT_W-1] ? -dot_s5_ff : dot_s5_ff;

   pipe_ctl_type     ctl_s6_ff;
   logic [DOT_W-1:0] adot_s6_ff;
   logic [N2_W-1:0]  rad_s6_ff;

   // front stage control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
         ctl_s4_ff <= '0;
         ctl_s5_ff <= '0;
         ctl_s6_ff <= '0;
      end else if (pipe_en) begin
         ctl_s1_ff <= ctl_s1_in;
         ctl_s2_ff <= ctl_s1_ff;
         ctl_s3_ff <= ctl_s2_ff;
         ctl_s4_ff <= ctl_s3_ff;
         ctl_s5_ff <= ctl_s4_ff;
         ctl_s6_ff <= ctl_s5_ff;
      end
   end

   // front stage data registers
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dmag_x_s1_ff <= dmag_x_in;
         dmag_y_s1_ff <= dmag_y_in;
         neg_x_s1_ff  <= diff_x[DIFF_W-1];
         neg_y_s1_ff  <= diff_y[DIFF_W-1];
         nx_s1_ff     <= req_normal_x;
         ny_s1_ff     <= req_normal_y;
         nz_s1_ff     <= req_normal_z;

         prod_x_s2_ff <= prod_x_in;
         prod_y_s2_ff <= prod_y_in;
         neg_x_s2_ff  <= neg_x_s1_ff;
         neg_y_s2_ff  <= neg_y_s1_ff;
         nx_s2_ff     <= nx_s1_ff;
         ny_s2_ff     <= ny_s1_ff;
         nz_s2_ff     <= nz_s1_ff;

         mag_x_s3_ff  <= mag_x_in;
         mag_y_s3_ff  <= mag_y_in;
         ray_x_s3_ff  <= ray_x_in;
         ray_y_s3_ff  <= ray_y_in;
         nx_s3_ff     <= nx_s2_ff;
         ny_s3_ff     <= ny_s2_ff;
         nz_s3_ff     <= nz_s2_ff;

         px_s4_ff     <= px_in;
         py_s4_ff     <= py_in;
         sqx_s4_ff    <= sqx_in;
         sqy_s4_ff    <= sqy_in;
         nz_s4_ff     <= nz_s3_ff;

         dot_s5_ff    <= dot_in;
         rad_s5_ff    <= rad_in;

         adot_s6_ff   <= adot_in;
         rad_s6_ff    <= rad_s5_ff;
      end
   end

   // ---------------------------------------------------------------
   // ray length and division
   // ---------------------------------------------------------------
   pipe_ctl_type      sq_ctl;
   logic [DOT_W-1:0]  sq_adot;
   logic [ROOT_W-1:0] sq_root;
   pipe_ctl_type      dv_ctl;
   logic [REL_W-1:0]  dv_rel;

   dnvr_sqrt_pipe u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .in_ctl   (ctl_s6_ff),
      .in_adot  (adot_s6_ff),
      .in_rad   (rad_s6_ff),
      .out_ctl  (sq_ctl),
      .out_adot (sq_adot),
      .out_root (sq_root)
   );

   dnvr_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .in_ctl   (sq_ctl),
      .in_adot  (sq_adot),
      .in_root  (sq_root),
      .out_ctl  (dv_ctl),
      .out_rel  (dv_rel)
   );

   // ---------------------------------------------------------------
   // output register with skid register
   // ---------------------------------------------------------------
   logic             rsp_valid_ff;
   logic [REL_W-1:0] rsp_rel_ff;
   logic [REL_W-1:0] skid_rel_ff;
   logic             out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // output and skid occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff | dv_ctl.valid;
         skid_valid_ff <= 1'b0;
      end else if (dv_ctl.valid & ~skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output and skid data
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_rel_ff <= skid_valid_ff ? skid_rel_ff : dv_rel;
      end else if (~skid_valid_ff) begin
         skid_rel_ff <= dv_rel;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reliability = rsp_rel_ff;

endmodule
